>>> rtl/core/xenc_pkg.sv
// Shared types and opcode constants for the x86-64 instruction byte encoder.
`default_nettype none

package xenc_pkg;

  // Longest instruction: REX.W + B8+r + imm64
  localparam int unsigned MaxBytes = 10;
  localparam int unsigned LenW     = 4;

  // Operation codes of the request
  typedef enum logic [4:0] {
    CMD_MOV_RR    = 5'd0,
    CMD_MOV_IMM64 = 5'd1,
    CMD_MOVSXD    = 5'd2,
    CMD_CMOVL     = 5'd3,
    CMD_CMOVG     = 5'd4,
    CMD_ADD_RR    = 5'd5,
    CMD_ADD_IMM   = 5'd6,
    CMD_SUB_RR    = 5'd7,
    CMD_SUB_IMM   = 5'd8,
    CMD_IMUL_RR   = 5'd9,
    CMD_IMUL_IMM  = 5'd10,
    CMD_IDIV      = 5'd11,
    CMD_NEG       = 5'd12,
    CMD_CQO       = 5'd13,
    CMD_CMP_RR    = 5'd14,
    CMD_CMP_IMM   = 5'd15,
    CMD_JE        = 5'd16,
    CMD_JNE       = 5'd17,
    CMD_JL        = 5'd18,
    CMD_JLE       = 5'd19,
    CMD_JG        = 5'd20,
    CMD_JGE       = 5'd21,
    CMD_JMP       = 5'd22,
    CMD_RET       = 5'd23,
    CMD_MOVSD_RR  = 5'd24,
    CMD_MULSD_RR  = 5'd25,
    CMD_MOVSD_RIP = 5'd26
  } cmd_e;

  // Fixed opcode bytes
  localparam logic [7:0] RexW      = 8'b0100_1000;
  localparam logic [7:0] RexBase   = 8'b0100_0000;
  localparam logic [7:0] OpMovRr   = 8'h89;
  localparam logic [7:0] OpMovImm  = 8'hB8;
  localparam logic [7:0] OpGrp1Imm = 8'h81;
  localparam logic [7:0] OpGrp3    = 8'hF7;
  localparam logic [7:0] OpEscape  = 8'h0F;
  localparam logic [7:0] PfxF2     = 8'hF2;
  localparam logic [7:0] OpJmp     = 8'hE9;
  localparam logic [7:0] OpRet     = 8'hC3;
  localparam logic [7:0] ModReg    = 8'b1100_0000;
  localparam logic [7:0] OpMovsxd  = 8'h63;
  localparam logic [7:0] OpCqo     = 8'h99;
  localparam logic [7:0] OpCmovl   = 8'h4C;
  localparam logic [7:0] OpCmovg   = 8'h4F;
  localparam logic [7:0] OpAddRr   = 8'h01;
  localparam logic [7:0] OpSubRr   = 8'h29;
  localparam logic [7:0] OpImulRr  = 8'hAF;
  localparam logic [7:0] OpImulImm = 8'h69;
  localparam logic [7:0] OpCmpRr   = 8'h39;
  localparam logic [7:0] OpJe      = 8'h84;
  localparam logic [7:0] OpJne     = 8'h85;
  localparam logic [7:0] OpJl      = 8'h8C;
  localparam logic [7:0] OpJle     = 8'h8E;
  localparam logic [7:0] OpJg      = 8'h8F;
  localparam logic [7:0] OpJge     = 8'h8D;
  localparam logic [7:0] OpMovsd   = 8'h10;
  localparam logic [7:0] OpMulsd   = 8'h59;

  // ModRM /digit extensions
  localparam logic [3:0] DigAdd  = 4'd0;
  localparam logic [3:0] DigNeg  = 4'd3;
  localparam logic [3:0] DigSub  = 4'd5;
  localparam logic [3:0] DigIdiv = 4'd7;
  localparam logic [3:0] DigCmp  = 4'd7;

  typedef struct packed {
    logic [4:0]         cmd;
    logic [3:0]         dst_reg;
    logic [3:0]         src_reg;
    logic signed [63:0] imm;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [31:0] byte_offset;
    logic        last;
    logic        error;
  } out_item_t;

  typedef logic [MaxBytes-1:0][7:0] byte_vec_t;

  // One encoded instruction as it sits in the queue
  typedef struct packed {
    byte_vec_t       bytes;
    logic [LenW-1:0] len;
    logic            err;
  } instr_t;

endpackage

`default_nettype wire

>>> rtl/core/xenc_front.sv
// Front end: classifies a request and assembles its machine bytes.
`default_nettype none

module xenc_front (
  input  xenc_pkg::in_item_t item_i,
  output xenc_pkg::instr_t   instr_o
);
  import xenc_pkg::*;

  typedef enum logic [3:0] {
    FMT_INT,
    FMT_IMM64,
    FMT_CQO,
    FMT_JCC,
    FMT_JMP,
    FMT_RET,
    FMT_SSE,
    FMT_RIP,
    FMT_ERR
  } fmt_e;

  fmt_e       fmt;
  logic [7:0] op;
  logic [7:0] op2;
  logic       two_op;
  logic       has_imm;
  logic [3:0] rm;
  logic [3:0] rg;
  logic [7:0] rex_int;
  logic [7:0] rex_sse;
  logic [7:0] modrm;
  logic [31:0] imm32;

  // Classify: pick format, opcode and operand roles
  always_comb begin
    fmt     = FMT_INT;
    op      = OpMovRr;
    op2     = OpMovRr;
    two_op  = 1'b0;
    has_imm = 1'b0;
    rm      = item_i.dst_reg;
    rg      = item_i.src_reg;
    unique case (cmd_e'(item_i.cmd))
      CMD_MOV_RR:    op = OpMovRr;
      CMD_MOV_IMM64: begin
        fmt = FMT_IMM64;
        op  = OpMovImm;
        rg  = 4'd0;
      end
      CMD_MOVSXD: begin
        op = OpMovsxd;
        rm = item_i.src_reg;
        rg = item_i.dst_reg;
      end
      CMD_CMOVL: begin
        op = OpEscape; op2 = OpCmovl; two_op = 1'b1;
        rm = item_i.src_reg; rg = item_i.dst_reg;
      end
      CMD_CMOVG: begin
        op = OpEscape; op2 = OpCmovg; two_op = 1'b1;
        rm = item_i.src_reg; rg = item_i.dst_reg;
      end
      CMD_ADD_RR: op = OpAddRr;
      CMD_ADD_IMM: begin
        op = OpGrp1Imm; rg = DigAdd; has_imm = 1'b1;
      end
      CMD_SUB_RR: op = OpSubRr;
      CMD_SUB_IMM: begin
        op = OpGrp1Imm; rg = DigSub; has_imm = 1'b1;
      end
      CMD_IMUL_RR: begin
        op = OpEscape; op2 = OpImulRr; two_op = 1'b1;
        rm = item_i.src_reg; rg = item_i.dst_reg;
      end
      CMD_IMUL_IMM: begin
        op = OpImulImm; has_imm = 1'b1;
        rm = item_i.src_reg; rg = item_i.dst_reg;
      end
      CMD_IDIV: begin
        op = OpGrp3; rg = DigIdiv;
      end
      CMD_NEG: begin
        op = OpGrp3; rg = DigNeg;
      end
      CMD_CQO:    fmt = FMT_CQO;
      CMD_CMP_RR: op = OpCmpRr;
      CMD_CMP_IMM: begin
        op = OpGrp1Imm; rg = DigCmp; has_imm = 1'b1;
      end
      CMD_JE: begin
        fmt = FMT_JCC; op = OpJe;
      end
      CMD_JNE: begin
        fmt = FMT_JCC; op = OpJne;
      end
      CMD_JL: begin
        fmt = FMT_JCC; op = OpJl;
      end
      CMD_JLE: begin
        fmt = FMT_JCC; op = OpJle;
      end
      CMD_JG: begin
        fmt = FMT_JCC; op = OpJg;
      end
      CMD_JGE: begin
        fmt = FMT_JCC; op = OpJge;
      end
      CMD_JMP: fmt = FMT_JMP;
      CMD_RET: fmt = FMT_RET;
      CMD_MOVSD_RR: begin
        fmt = FMT_SSE; op = OpMovsd;
        rm = item_i.src_reg; rg = item_i.dst_reg;
      end
      CMD_MULSD_RR: begin
        fmt = FMT_SSE; op = OpMulsd;
        rm = item_i.src_reg; rg = item_i.dst_reg;
      end
      CMD_MOVSD_RIP: begin
        rg  = item_i.dst_reg;
        fmt = item_i.dst_reg[3] ? FMT_ERR : FMT_RIP;
      end
      default: fmt = FMT_ERR;
    endcase
  end

  // Prefix and ModRM fields
  assign rex_int = RexW | {5'b0, rg[3], 1'b0, rm[3]};
  assign rex_sse = RexBase | {5'b0, rg[3], 1'b0, rm[3]};
  assign modrm   = ModReg | {2'b00, rg[2:0], rm[2:0]};
  assign imm32   = item_i.imm[31:0];

  // Assemble bytes, first byte at index 0
  always_comb begin
    instr_o = '0;
    unique case (fmt)
      FMT_INT: begin
        instr_o.bytes[0] = rex_int;
        instr_o.bytes[1] = op;
        if (two_op) begin
          instr_o.bytes[2] = op2;
          instr_o.bytes[3] = modrm;
          instr_o.len      = LenW'(4);
        end else if (has_imm) begin
          instr_o.bytes[2]   = modrm;
          instr_o.bytes[6:3] = imm32;
          instr_o.len        = LenW'(7);
        end else begin
          instr_o.bytes[2] = modrm;
          instr_o.len      = LenW'(3);
        end
      end
      FMT_IMM64: begin
        instr_o.bytes[0]   = rex_int;
        instr_o.bytes[1]   = op | {5'b0, rm[2:0]};
        instr_o.bytes[9:2] = item_i.imm;
        instr_o.len        = LenW'(10);
      end
      FMT_CQO: begin
        instr_o.bytes[0] = RexW;
        instr_o.bytes[1] = OpCqo;
        instr_o.len      = LenW'(2);
      end
      FMT_JCC: begin
        instr_o.bytes[0]   = OpEscape;
        instr_o.bytes[1]   = op;
        instr_o.bytes[5:2] = imm32;
        instr_o.len        = LenW'(6);
      end
      FMT_JMP: begin
        instr_o.bytes[0]   = OpJmp;
        instr_o.bytes[4:1] = imm32;
        instr_o.len        = LenW'(5);
      end
      FMT_RET: begin
        instr_o.bytes[0] = OpRet;
        instr_o.len      = LenW'(1);
      end
      FMT_SSE: begin
        instr_o.bytes[0] = PfxF2;
        if (rex_sse != RexBase) begin
          instr_o.bytes[1] = rex_sse;
          instr_o.bytes[2] = OpEscape;
          instr_o.bytes[3] = op;
          instr_o.bytes[4] = modrm;
          instr_o.len      = LenW'(5);
        end else begin
          instr_o.bytes[1] = OpEscape;
          instr_o.bytes[2] = op;
          instr_o.bytes[3] = modrm;
          instr_o.len      = LenW'(4);
        end
      end
      FMT_RIP: begin
        // mod 00, rm 101: rip-relative disp32
        instr_o.bytes[0]   = PfxF2;
        instr_o.bytes[1]   = OpEscape;
        instr_o.bytes[2]   = OpMovsd;
        instr_o.bytes[3]   = {2'b00, rg[2:0], 3'b101};
        instr_o.bytes[7:4] = imm32;
        instr_o.len        = LenW'(8);
      end
      default: begin
        // rejected request: one zero byte flagged as error
        instr_o.len = LenW'(1);
        instr_o.err = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/xenc_fifo.sv
// Short queue of encoded instructions between front and back end.
`default_nettype none

module xenc_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  xenc_pkg::instr_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output xenc_pkg::instr_t head_o
);
  import xenc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  instr_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o       = (cnt_q == FullCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/xenc_back.sv
// Back end: serializes queued instructions one byte per cycle with offsets, while the output is not stalled.
`default_nettype none

module xenc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  xenc_pkg::instr_t    head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output xenc_pkg::out_item_t out_item_o
);
  import xenc_pkg::*;

  logic [LenW-1:0] idx_q, idx_d;
  logic [31:0]     off_q, off_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q;
  logic            advance;
  logic            emit;
  logic            is_last;
  logic [LenW-1:0] last_idx;

  // Output register frees up when empty or taken this cycle
  assign advance  = !out_valid_q || !out_stall_i;
  assign emit     = advance && head_valid_i;
  assign last_idx = head_i.len - LenW'(1);
  assign is_last  = head_i.err || (idx_q == last_idx);
  assign pop_o    = emit && is_last;

  always_comb begin
    idx_d       = idx_q;
    off_d       = off_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = head_valid_i;
    end
    if (emit) begin
      idx_d = is_last ? '0 : idx_q + LenW'(1);
      // rejected requests do not move the offset
      if (!head_i.err) begin
        off_d = off_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      off_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      off_q       <= off_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_byte    <= head_i.bytes[idx_q];
      out_q.byte_offset <= off_q;
      out_q.last        <= is_last;
      out_q.error       <= head_i.err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/core/x86_64_instruction_byte_encoder.sv
// Each request is registered in the queue, and its bytes then pass through the output register.
// Throughput: one byte per cycle while the output is not stalled, set by the single-byte output
// register; an instruction of 1 to 10 bytes holds the serializer until its last byte is emitted.
// The queue of QueueDepth encoded instructions lets requests be taken while bytes drain.
// Reset: empties the queue, drops the output valid and sets the code offset to zero.
`default_nettype none

module x86_64_instruction_byte_encoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  xenc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output xenc_pkg::out_item_t out_item_o
);
  import xenc_pkg::*;

  instr_t front_instr;
  instr_t head;
  logic   queue_full;
  logic   head_valid;
  logic   pop;

  // Decode a request into its byte image
  xenc_front u_front (
    .item_i  (in_item_i),
    .instr_o (front_instr)
  );

  // Decoupling queue
  xenc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_data_i  (front_instr),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  assign in_stall_o = queue_full;

  // Byte serializer
  xenc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the x86-64 instruction byte encoder.
`default_nettype none

module testbench;
  import xenc_pkg::*;

  // Undefined operation codes and immediate extremes
  localparam logic [4:0] CmdUndefLo = 5'd27;
  localparam logic [4:0] CmdUndefHi = 5'd31;
  localparam logic [2:0] RipDispRm  = 3'b101;
  localparam logic signed [63:0] ImmMin  = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] ImmMax  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ImmOnes = -64'sd1;
  localparam logic signed [63:0] ImmMix  = 64'sh0123_4567_89AB_CDEF;
  localparam int LongHoldCycles = 150;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // Instruction model state and expected byte stream
  logic [7:0]  instr_bytes[$];
  out_item_t   expected_bytes[$];
  logic [31:0] code_offset_model;
  out_item_t   want_byte;
  int          mismatch_count;

  // Idle and stall controls
  bit sender_idle_on;
  bit recv_stall_on;
  bit long_hold_req;
  int hold_left;

  x86_64_instruction_byte_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Safety net against a hung handshake
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Encoding predictor
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rex_of(logic [7:0] base, logic [3:0] rm, logic [3:0] rg);
    return base | {5'b0, rg[3], 1'b0, rm[3]};
  endfunction

  function automatic logic [7:0] modrm_of(logic [3:0] rm, logic [3:0] rg);
    return ModReg | {2'b00, rg[2:0], rm[2:0]};
  endfunction

  // Append one byte to the instruction image
  function void append_byte(logic [7:0] b);
    instr_bytes = {instr_bytes, b};
  endfunction

  // Append one expected result transaction
  function void append_expected(out_item_t e);
    expected_bytes = {expected_bytes, e};
  endfunction

  function void emit_disp32(logic [63:0] v);
    for (int i = 0; i < 4; i++) append_byte(v[8*i +: 8]);
  endfunction

  // REX.W op [op2] ModRM
  function void emit_int_rr(logic [7:0] op, logic [7:0] op2, bit two,
                            logic [3:0] rm, logic [3:0] rg);
    append_byte(rex_of(RexW, rm, rg));
    append_byte(op);
    if (two) append_byte(op2);
    append_byte(modrm_of(rm, rg));
  endfunction

  // F2 [REX] 0F op ModRM; REX only for extended registers
  function void emit_sse_rr(logic [7:0] op, logic [3:0] dst, logic [3:0] src);
    logic [7:0] rex;
    rex = rex_of(RexBase, src, dst);
    append_byte(PfxF2);
    if (rex != RexBase) append_byte(rex);
    append_byte(OpEscape);
    append_byte(op);
    append_byte(modrm_of(src, dst));
  endfunction

  function void encode_request(in_item_t req);
    bit rejected;
    logic [3:0] d;
    logic [3:0] s;
    rejected = 1'b0;
    d = req.dst_reg;
    s = req.src_reg;
    instr_bytes.delete();
    case (req.cmd)
      CMD_MOV_RR:   emit_int_rr(OpMovRr, 8'h00, 1'b0, d, s);
      CMD_MOV_IMM64: begin
        append_byte(rex_of(RexW, d, 4'd0));
        append_byte(OpMovImm | {5'b0, d[2:0]});
        for (int i = 0; i < 8; i++) append_byte(req.imm[8*i +: 8]);
      end
      CMD_MOVSXD:   emit_int_rr(OpMovsxd, 8'h00, 1'b0, s, d);
      CMD_CMOVL:    emit_int_rr(OpEscape, OpCmovl, 1'b1, s, d);
      CMD_CMOVG:    emit_int_rr(OpEscape, OpCmovg, 1'b1, s, d);
      CMD_ADD_RR:   emit_int_rr(OpAddRr, 8'h00, 1'b0, d, s);
      CMD_ADD_IMM: begin
        emit_int_rr(OpGrp1Imm, 8'h00, 1'b0, d, DigAdd);
        emit_disp32(req.imm);
      end
      CMD_SUB_RR:   emit_int_rr(OpSubRr, 8'h00, 1'b0, d, s);
      CMD_SUB_IMM: begin
        emit_int_rr(OpGrp1Imm, 8'h00, 1'b0, d, DigSub);
        emit_disp32(req.imm);
      end
      CMD_IMUL_RR:  emit_int_rr(OpEscape, OpImulRr, 1'b1, s, d);
      CMD_IMUL_IMM: begin
        emit_int_rr(OpImulImm, 8'h00, 1'b0, s, d);
        emit_disp32(req.imm);
      end
      CMD_IDIV:     emit_int_rr(OpGrp3, 8'h00, 1'b0, d, DigIdiv);
      CMD_NEG:      emit_int_rr(OpGrp3, 8'h00, 1'b0, d, DigNeg);
      CMD_CQO: begin
        append_byte(RexW);
        append_byte(OpCqo);
      end
      CMD_CMP_RR:   emit_int_rr(OpCmpRr, 8'h00, 1'b0, d, s);
      CMD_CMP_IMM: begin
        emit_int_rr(OpGrp1Imm, 8'h00, 1'b0, d, DigCmp);
        emit_disp32(req.imm);
      end
      CMD_JE, CMD_JNE, CMD_JL, CMD_JLE, CMD_JG, CMD_JGE: begin
        append_byte(OpEscape);
        case (req.cmd)
          CMD_JE:  append_byte(OpJe);
          CMD_JNE: append_byte(OpJne);
          CMD_JL:  append_byte(OpJl);
          CMD_JLE: append_byte(OpJle);
          CMD_JG:  append_byte(OpJg);
          default: append_byte(OpJge);
        endcase
        emit_disp32(req.imm);
      end
      CMD_JMP: begin
        append_byte(OpJmp);
        emit_disp32(req.imm);
      end
      CMD_RET:      append_byte(OpRet);
      CMD_MOVSD_RR: emit_sse_rr(OpMovsd, d, s);
      CMD_MULSD_RR: emit_sse_rr(OpMulsd, d, s);
      CMD_MOVSD_RIP: begin
        // xmm8-15 would need a REX byte, which this form does not support
        if (d[3]) begin
          rejected = 1'b1;
        end else begin
          append_byte(PfxF2);
          append_byte(OpEscape);
          append_byte(OpMovsd);
          append_byte({2'b00, d[2:0], RipDispRm});
          emit_disp32(req.imm);
        end
      end
      default:      rejected = 1'b1;
    endcase

    // Rejected requests give one zero byte and leave the offset alone
    if (rejected) begin
      append_expected(out_item_t'{out_byte: 8'h00, byte_offset: code_offset_model,
                                  last: 1'b1, error: 1'b1});
    end else begin
      foreach (instr_bytes[i]) begin
        append_expected(out_item_t'{out_byte: instr_bytes[i],
                                    byte_offset: code_offset_model,
                                    last: (i == instr_bytes.size() - 1),
                                    error: 1'b0});
        code_offset_model = code_offset_model + 32'd1;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: stall generation and byte checking
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (long_hold_req) begin
      // long hold-off so the encoder queue fills and stalls its input
      long_hold_req = 1'b0;
      hold_left = LongHoldCycles;
      out_stall <= 1'b1;
    end else if (!recv_stall_on) begin
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:69]:  out_stall <= 1'b0;
        [70:95]: begin
          out_stall <= 1'b1;
          hold_left = $urandom_range(0, 3);
        end
        default: begin
          out_stall <= 1'b1;
          hold_left = $urandom_range(5, 25);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte %02h at offset %08h", out_item.out_byte, out_item.byte_offset);
        mismatch_count++;
      end else begin
        want_byte = expected_bytes.pop_front();
        if (out_item.out_byte !== want_byte.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want_byte.out_byte, out_item.out_byte);
          mismatch_count++;
        end
        if (out_item.byte_offset !== want_byte.byte_offset) begin
          $error("byte_offset: expected %08h, got %08h",
                 want_byte.byte_offset, out_item.byte_offset);
          mismatch_count++;
        end
        if (out_item.last !== want_byte.last) begin
          $error("last: expected %0b, got %0b", want_byte.last, out_item.last);
          mismatch_count++;
        end
        if (out_item.error !== want_byte.error) begin
          $error("error: expected %0b, got %0b", want_byte.error, out_item.error);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    if (!sender_idle_on) return 0;
    case ($urandom_range(0, 99)) inside
      [0:49]:  return 0;
      [50:84]: return $urandom_range(1, 3);
      [85:96]: return $urandom_range(4, 10);
      default: return $urandom_range(20, 40);
    endcase
  endfunction

  // Offer one request, wait for the transaction, then idle for a random gap, which may be zero
  task automatic send_request(in_item_t req);
    int gap;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    encode_request(req);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Drop valid and hold until every expected byte has come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  function automatic in_item_t random_request();
    in_item_t req;
    req.cmd     = ($urandom_range(0, 99) < 5) ? 5'($urandom_range(CmdUndefLo, CmdUndefHi))
                                             : 5'($urandom_range(0, CMD_MOVSD_RIP));
    req.dst_reg = 4'($urandom_range(0, 15));
    req.src_reg = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0:       req.imm = ImmMin;
      1:       req.imm = ImmMax;
      2:       req.imm = -$signed({56'd0, 8'($urandom_range(0, 255))});
      default: req.imm = {$urandom, $urandom};
    endcase
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every operation once, registers at 0 and 15, immediates from a set of extreme and mixed values
  task automatic test_each_operation();
    in_item_t req;
    for (int c = 0; c <= CMD_MOVSD_RIP; c++) begin
      req.cmd     = c[4:0];
      req.dst_reg = c[0] ? 4'd15 : 4'd0;
      req.src_reg = c[1] ? 4'd15 : 4'd0;
      case (c % 5)
        0: req.imm = ImmMin;
        1: req.imm = ImmMax;
        2: req.imm = ImmOnes;
        3: req.imm = '0;
        default: req.imm = ImmMix;
      endcase
      send_request(req);
    end
    wait_drained();
  endtask

  // Undefined operations and rip-relative movsd with an extended register
  task automatic test_rejected_requests();
    in_item_t req;
    req = '{cmd: CmdUndefLo, dst_reg: 4'd3, src_reg: 4'd12, imm: ImmMix};
    send_request(req);
    req = '{cmd: CmdUndefHi, dst_reg: 4'd15, src_reg: 4'd15, imm: ImmOnes};
    send_request(req);
    req = '{cmd: CMD_MOVSD_RIP, dst_reg: 4'd8, src_reg: 4'd0, imm: ImmMax};
    send_request(req);
    wait_drained();
  endtask

  // Random instruction mix through phases with and without sender idling and receiver stalls
  task automatic test_random_stream();
    for (int n = 0; n < 150; n++) begin
      case (n / 50)
        0: begin sender_idle_on = 1'b1; recv_stall_on = 1'b1; end
        1: begin sender_idle_on = 1'b0; recv_stall_on = 1'b0; end
        default: begin sender_idle_on = 1'b1; recv_stall_on = 1'b0; end
      endcase
      send_request(random_request());
    end
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_output_backpressure();
    sender_idle_on = 1'b0;
    recv_stall_on  = 1'b1;
    long_hold_req  = 1'b1;
    for (int n = 0; n < 30; n++) send_request(random_request());
    wait_drained();
  endtask

  // Short bursts, each followed by a full drain
  task automatic test_sender_pause();
    sender_idle_on = 1'b1;
    recv_stall_on  = 1'b1;
    for (int burst = 0; burst < 4; burst++) begin
      for (int n = 0; n < 5; n++) send_request(random_request());
      wait_drained();
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_valid          = 1'b0;
    in_item           = '0;
    out_stall         = 1'b0;
    code_offset_model = '0;
    mismatch_count    = 0;
    sender_idle_on    = 1'b1;
    recv_stall_on     = 1'b1;
    long_hold_req     = 1'b0;
    hold_left         = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_each_operation();
    test_rejected_requests();
    test_random_stream();
    test_output_backpressure();
    test_sender_pause();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/core/xenc_pkg.sv
rtl/core/xenc_front.sv
rtl/core/xenc_fifo.sv
rtl/core/xenc_back.sv
rtl/core/x86_64_instruction_byte_encoder.sv
tb/sv/testbench.sv
